FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
// ante at one edge implies cons at the same edge
// ante at one edge implies cons at the next edge
`ifndef ASSERT_OFF
`define LVM_ASSERT_HOLDS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lookat assertion failed");
`define LVM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lookat assertion failed");
`define LVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lookat assertion failed");
`else
`define LVM_ASSERT_HOLDS(lbl, clk, rst_n, cond)
`define LVM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/lvm_pkg.sv
package lvm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    // magnitudes are scaled so the largest one lies in [2^29, 2^30)
    localparam int NORM_W        = 30;
    localparam int CFG_IDX_W     = 3;
    localparam logic [1:0] LAST_COL = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_X,
        CFG_TARGET_Y,
        CFG_TARGET_Z,
        CFG_UPVEC_X,
        CFG_UPVEC_Y,
        CFG_UPVEC_Z
    } cfg_index_t;

endpackage

FILE: design/lvm_isqrt.sv
module lvm_isqrt #(
    parameter int XW = 62,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [XW-1:0] in_x,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [XW/2-1:0] out_root,
    output logic [SW-1:0] out_side
);

    localparam int RW = XW / 2;

    logic          v_s    [RW+1];
    logic [XW:0]   rem_s  [RW+1];
    logic [XW:0]   res_s  [RW+1];
    logic [SW-1:0] side_s [RW+1];

    assign v_s[0]    = in_valid;
    assign rem_s[0]  = {1'b0, in_x};
    assign res_s[0]  = '0;
    assign side_s[0] = in_side;

    // one result bit per stage
    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam int SH = 2 * (RW - 1 - k);
        localparam logic [XW:0] BITC = {{XW{1'b0}}, 1'b1} << SH;
        logic [XW:0] trial;

        assign trial = res_s[k] + BITC;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_s[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_s[k+1] <= v_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_s[k] >= trial)
                begin
                    rem_s[k+1] <= rem_s[k] - trial;
                    res_s[k+1] <= (res_s[k] >> 1) + BITC;
                end
                else
                begin
                    rem_s[k+1] <= rem_s[k];
                    res_s[k+1] <= res_s[k] >> 1;
                end
                side_s[k+1] <= side_s[k];
            end
        end
    end

    assign out_valid = v_s[RW];
    assign out_root  = res_s[RW][RW-1:0];
    assign out_side  = side_s[RW];

endmodule

FILE: design/lvm_unitize.sv
module lvm_unitize #(
    parameter int VW        = 33,
    parameter int SW        = 1,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [VW-1:0]        in_vec [3],
    input  logic [SW-1:0]               in_side,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+1:0] out_unit [3],
    output logic                        out_ok,
    output logic [SW-1:0]               out_side
);

    localparam int NW  = lvm_pkg::NORM_W;
    localparam int PW  = $clog2(VW);
    localparam int SQW = 2 * NW;
    localparam int XW  = 2 * NW + 2;
    localparam int RW  = XW / 2;
    localparam int QW  = FRAC_BITS + 1;
    localparam int UW  = FRAC_BITS + 2;
    localparam int DNW = NW + 1 + FRAC_BITS;
    localparam int DRW = RW;
    localparam int TW  = SW + 3 + 1 + 3 * NW;

    // stage 0: magnitudes
    logic          v0_reg;
    logic [VW-1:0] mag0_reg [3];
    logic [2:0]    sgn0_reg;
    logic [SW-1:0] side0_reg;

    // stage 1: leading one
    logic          v1_reg;
    logic [VW-1:0] mag1_reg [3];
    logic [2:0]    sgn1_reg;
    logic [SW-1:0] side1_reg;
    logic [PW-1:0] pos1_reg;
    logic          zero1_reg;
    logic [VW-1:0] or_all;
    logic [PW-1:0] pos_next;

    // stage 2: scaled magnitudes
    logic          v2_reg;
    logic [NW-1:0] mag2_reg [3];
    logic [2:0]    sgn2_reg;
    logic [SW-1:0] side2_reg;
    logic          zero2_reg;
    logic [VW-1:0] sh_w [3];

    // stage 3: squares
    logic           v3_reg;
    logic [NW-1:0]  mag3_reg [3];
    logic [SQW-1:0] sq3_reg [3];
    logic [2:0]     sgn3_reg;
    logic [SW-1:0]  side3_reg;
    logic           zero3_reg;

    // stage 4: sum of squares
    logic          v4_reg;
    logic [NW-1:0] mag4_reg [3];
    logic [XW-1:0] sum4_reg;
    logic [2:0]    sgn4_reg;
    logic [SW-1:0] side4_reg;
    logic          zero4_reg;

    logic          sq_valid;
    logic [RW-1:0] sq_root;
    logic [TW-1:0] sq_side;

    // stage 5: rounded dividends
    logic           v5_reg;
    logic [DNW-1:0] num5_reg [3];
    logic [DRW-1:0] len5_reg;
    logic [2:0]     sgn5_reg;
    logic [SW-1:0]  side5_reg;
    logic           zero5_reg;

    logic           dv    [QW+1];
    logic [DRW-1:0] drem  [QW+1][3];
    logic [DNW-1:0] dnum  [QW+1][3];
    logic [QW-1:0]  dq    [QW+1][3];
    logic [DRW-1:0] dlen  [QW+1];
    logic [2:0]     dsgn  [QW+1];
    logic           dzero [QW+1];
    logic [SW-1:0]  dside [QW+1];

    logic signed [UW-1:0] qs [3];
    logic signed [UW-1:0] unit_next [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= sq_valid;
            out_valid <= dv[QW];
        end
    end

    assign or_all = mag0_reg[0] | mag0_reg[1] | mag0_reg[2];

    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < VW; i++)
        begin
            if (or_all[i])
            begin
                pos_next = PW'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pos1_reg >= PW'(NW - 1))
            begin
                sh_w[i] = mag1_reg[i] >> (pos1_reg - PW'(NW - 1));
            end
            else
            begin
                sh_w[i] = mag1_reg[i] << (PW'(NW - 1) - pos1_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag0_reg[i] <= in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]);
                sgn0_reg[i] <= in_vec[i][VW-1];
                mag1_reg[i] <= mag0_reg[i];
                mag2_reg[i] <= sh_w[i][NW-1:0];
                mag3_reg[i] <= mag2_reg[i];
                sq3_reg[i]  <= SQW'(mag2_reg[i]) * SQW'(mag2_reg[i]);
                mag4_reg[i] <= mag3_reg[i];
            end
            side0_reg <= in_side;
            sgn1_reg  <= sgn0_reg;
            side1_reg <= side0_reg;
            pos1_reg  <= pos_next;
            zero1_reg <= (or_all == '0);
            sgn2_reg  <= sgn1_reg;
            side2_reg <= side1_reg;
            zero2_reg <= zero1_reg;
            sgn3_reg  <= sgn2_reg;
            side3_reg <= side2_reg;
            zero3_reg <= zero2_reg;
            sum4_reg  <= XW'(sq3_reg[0]) + XW'(sq3_reg[1]) + XW'(sq3_reg[2]);
            sgn4_reg  <= sgn3_reg;
            side4_reg <= side3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    lvm_isqrt #(
        .XW (XW),
        .SW (TW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_x      (sum4_reg),
        .in_side   ({side4_reg, sgn4_reg, zero4_reg, mag4_reg[0], mag4_reg[1], mag4_reg[2]}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // dividend carries half the divisor for round half up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num5_reg[i] <= (DNW'(sq_side[(2 - i) * NW +: NW]) << FRAC_BITS)
                             + DNW'(sq_root >> 1);
            end
            len5_reg  <= sq_root;
            zero5_reg <= sq_side[3 * NW];
            sgn5_reg  <= sq_side[3 * NW + 1 +: 3];
            side5_reg <= sq_side[3 * NW + 4 +: SW];
        end
    end

    assign dv[0]    = v5_reg;
    assign dlen[0]  = len5_reg;
    assign dsgn[0]  = sgn5_reg;
    assign dzero[0] = zero5_reg;
    assign dside[0] = side5_reg;

    for (genvar i = 0; i < 3; i++) begin : g_lane0
        assign drem[0][i] = DRW'(num5_reg[i] >> QW);
        assign dnum[0][i] = num5_reg[i];
        assign dq[0][i]   = '0;
    end

    // restoring division, one quotient bit per stage in three lanes
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int B = QW - 1 - k;
        logic [DRW:0] trial [3];
        logic [2:0]   ge;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {drem[k][i], dnum[k][i][B]};
                ge[i]    = (trial[i] >= {1'b0, dlen[k]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv[k+1] <= dv[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (ge[i])
                    begin
                        drem[k+1][i] <= DRW'(trial[i] - {1'b0, dlen[k]});
                        dq[k+1][i]   <= dq[k][i] | (QW'(1) << B);
                    end
                    else
                    begin
                        drem[k+1][i] <= trial[i][DRW-1:0];
                        dq[k+1][i]   <= dq[k][i];
                    end
                    dnum[k+1][i] <= dnum[k][i];
                end
                dlen[k+1]  <= dlen[k];
                dsgn[k+1]  <= dsgn[k];
                dzero[k+1] <= dzero[k];
                dside[k+1] <= dside[k];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qs[i] = $signed({1'b0, dq[QW][i]});
            if (dzero[QW])
            begin
                unit_next[i] = '0;
            end
            else if (dsgn[QW][i])
            begin
                unit_next[i] = -qs[i];
            end
            else
            begin
                unit_next[i] = qs[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_unit[i] <= unit_next[i];
            end
            out_ok   <= !dzero[QW];
            out_side <= dside[QW];
        end
    end

endmodule

FILE: design/lookat_view_matrix.sv
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// input     | in_valid / in_ready  | eye_x, eye_y, eye_z
// result    | out_valid / out_ready| column_index, elem_0..elem_3, degenerate, last
// config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// an eye position enters in any cycle the pipeline moves; it yields four column
// transfers, so the result port sets the rate at which eyes are taken
// the pipeline depth to the first column is set by the two normalizers (square root and
// divide, one bit per stage each)
// the whole pipeline advances together and holds while the column serializer is busy
// reset clears all valid bits and loads target (0,0,0) and up (0,1.0,0)
`include "assert_macros.svh"

module lookat_view_matrix #(
    parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [lvm_pkg::COORD_W-1:0]  eye_x,
    input  logic signed [lvm_pkg::COORD_W-1:0]  eye_y,
    input  logic signed [lvm_pkg::COORD_W-1:0]  eye_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          column_index,
    output logic signed [lvm_pkg::COORD_W-1:0]  elem_0,
    output logic signed [lvm_pkg::COORD_W-1:0]  elem_1,
    output logic signed [lvm_pkg::COORD_W-1:0]  elem_2,
    output logic signed [lvm_pkg::COORD_W-1:0]  elem_3,
    output logic                                degenerate,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lvm_pkg::COORD_W-1:0]         cfg_data
);

    localparam int CDW  = lvm_pkg::COORD_W;
    localparam int UW   = FRAC_BITS + 2;
    localparam int PRW  = UW + CDW;
    localparam int CW   = PRW + 1;
    localparam int RFW  = 2 * UW;
    localparam int UWR  = RFW + 1;
    localparam int DOTW = PRW + 2;
    localparam int UW2  = UWR - FRAC_BITS;
    localparam int UEW  = UW2 + CDW;
    localparam int DUW  = UEW + 2;
    localparam int SW1  = 3 * CDW;
    localparam int SW2  = 3 * CDW + 3 * UW + 1;

    localparam logic signed [CDW-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
        rnd = (x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [CDW-1:0] sat(input logic signed [63:0] x);
        if (x > MAX32)
        begin
            sat = MAX32[CDW-1:0];
        end
        else if (x < MIN32)
        begin
            sat = MIN32[CDW-1:0];
        end
        else
        begin
            sat = x[CDW-1:0];
        end
    endfunction

    logic signed [CDW-1:0] target_x_reg, target_y_reg, target_z_reg;
    logic signed [CDW-1:0] upvec_x_reg, upvec_y_reg, upvec_z_reg;

    logic en;

    // stage a: forward difference
    logic                  a_valid_reg;
    logic signed [CDW-1:0] a_eye_reg [3];
    logic signed [CDW:0]   a_d_reg [3];

    logic                  u1_valid;
    logic signed [UW-1:0]  u1_f [3];
    logic                  u1_ok;
    logic [SW1-1:0]        u1_side;

    // stage b: forward times up products
    logic                  b_valid_reg;
    logic signed [CDW-1:0] b_eye_reg [3];
    logic signed [UW-1:0]  b_f_reg [3];
    logic                  b_ok_reg;
    logic signed [PRW-1:0] b_p_reg [6];

    // stage c: cross product
    logic                  c_valid_reg;
    logic signed [CDW-1:0] c_eye_reg [3];
    logic signed [UW-1:0]  c_f_reg [3];
    logic                  c_ok_reg;
    logic signed [CW-1:0]  c_d_reg [3];

    logic                  u2_valid;
    logic signed [UW-1:0]  u2_r [3];
    logic                  u2_ok;
    logic [SW2-1:0]        u2_side;
    logic signed [CDW-1:0] u2_eye [3];
    logic signed [UW-1:0]  u2_f [3];

    // stage d: products for recomputed up and the dots
    logic                  d_valid_reg;
    logic signed [CDW-1:0] d_eye_reg [3];
    logic signed [UW-1:0]  d_r_reg [3];
    logic signed [UW-1:0]  d_f_reg [3];
    logic                  d_ok_reg;
    logic signed [RFW-1:0] d_rf_reg [6];
    logic signed [PRW-1:0] d_re_reg [3];
    logic signed [PRW-1:0] d_fe_reg [3];

    // stage e: sums
    logic                   e_valid_reg;
    logic signed [CDW-1:0]  e_eye_reg [3];
    logic signed [UW-1:0]   e_r_reg [3];
    logic signed [UW-1:0]   e_f_reg [3];
    logic                   e_ok_reg;
    logic signed [UWR-1:0]  e_ur_reg [3];
    logic signed [DOTW-1:0] e_dr_reg;
    logic signed [DOTW-1:0] e_df_reg;

    // stage g: rounding
    logic                  g_valid_reg;
    logic signed [CDW-1:0] g_eye_reg [3];
    logic signed [UW-1:0]  g_r_reg [3];
    logic signed [UW-1:0]  g_f_reg [3];
    logic                  g_ok_reg;
    logic signed [UW2-1:0] g_u_reg [3];
    logic signed [CDW-1:0] g_tr_reg;
    logic signed [CDW-1:0] g_tf_reg;
    logic signed [63:0]    u_rnd [3];

    // stage h: up times eye
    logic                  h_valid_reg;
    logic signed [UW-1:0]  h_r_reg [3];
    logic signed [UW-1:0]  h_f_reg [3];
    logic                  h_ok_reg;
    logic signed [UW2-1:0] h_u_reg [3];
    logic signed [CDW-1:0] h_tr_reg;
    logic signed [CDW-1:0] h_tf_reg;
    logic signed [UEW-1:0] h_ue_reg [3];

    // stage j: up dot
    logic                  j_valid_reg;
    logic signed [UW-1:0]  j_r_reg [3];
    logic signed [UW-1:0]  j_f_reg [3];
    logic                  j_ok_reg;
    logic signed [UW2-1:0] j_u_reg [3];
    logic signed [CDW-1:0] j_tr_reg;
    logic signed [CDW-1:0] j_tf_reg;
    logic signed [DUW-1:0] j_du_reg;

    // column serializer
    logic                  s_valid_reg;
    logic [1:0]            col_reg;
    logic signed [UW-1:0]  s_r_reg [3];
    logic signed [UW-1:0]  s_f_reg [3];
    logic signed [UW2-1:0] s_u_reg [3];
    logic signed [CDW-1:0] s_t_reg [3];
    logic                  s_deg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg <= '0;
            target_y_reg <= '0;
            target_z_reg <= '0;
            upvec_x_reg  <= '0;
            upvec_y_reg  <= ONE_Q;
            upvec_z_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lvm_pkg::CFG_TARGET_X: target_x_reg <= $signed(cfg_data);
                lvm_pkg::CFG_TARGET_Y: target_y_reg <= $signed(cfg_data);
                lvm_pkg::CFG_TARGET_Z: target_z_reg <= $signed(cfg_data);
                lvm_pkg::CFG_UPVEC_X:  upvec_x_reg  <= $signed(cfg_data);
                lvm_pkg::CFG_UPVEC_Y:  upvec_y_reg  <= $signed(cfg_data);
                lvm_pkg::CFG_UPVEC_Z:  upvec_z_reg  <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // everything moves unless the serializer still has columns to send
    assign en       = !s_valid_reg || (out_ready && col_reg == lvm_pkg::LAST_COL);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            col_reg     <= '0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= u1_valid;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= u2_valid;
            e_valid_reg <= d_valid_reg;
            g_valid_reg <= e_valid_reg;
            h_valid_reg <= g_valid_reg;
            j_valid_reg <= h_valid_reg;
            s_valid_reg <= j_valid_reg;
            col_reg     <= '0;
        end
        else if (out_ready)
        begin
            col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_eye_reg[0] <= eye_x;
            a_eye_reg[1] <= eye_y;
            a_eye_reg[2] <= eye_z;
            a_d_reg[0]   <= (CDW+1)'(target_x_reg) - (CDW+1)'(eye_x);
            a_d_reg[1]   <= (CDW+1)'(target_y_reg) - (CDW+1)'(eye_y);
            a_d_reg[2]   <= (CDW+1)'(target_z_reg) - (CDW+1)'(eye_z);
        end
    end

    lvm_unitize #(
        .VW        (CDW + 1),
        .SW        (SW1),
        .FRAC_BITS (FRAC_BITS)
    ) u_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_vec    (a_d_reg),
        .in_side   ({a_eye_reg[0], a_eye_reg[1], a_eye_reg[2]}),
        .out_valid (u1_valid),
        .out_unit  (u1_f),
        .out_ok    (u1_ok),
        .out_side  (u1_side)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_eye_reg[0] <= $signed(u1_side[2*CDW +: CDW]);
            b_eye_reg[1] <= $signed(u1_side[CDW +: CDW]);
            b_eye_reg[2] <= $signed(u1_side[0 +: CDW]);
            for (int i = 0; i < 3; i++)
            begin
                b_f_reg[i] <= u1_f[i];
            end
            b_ok_reg   <= u1_ok;
            b_p_reg[0] <= PRW'(u1_f[1]) * PRW'(upvec_z_reg);
            b_p_reg[1] <= PRW'(u1_f[2]) * PRW'(upvec_y_reg);
            b_p_reg[2] <= PRW'(u1_f[2]) * PRW'(upvec_x_reg);
            b_p_reg[3] <= PRW'(u1_f[0]) * PRW'(upvec_z_reg);
            b_p_reg[4] <= PRW'(u1_f[0]) * PRW'(upvec_y_reg);
            b_p_reg[5] <= PRW'(u1_f[1]) * PRW'(upvec_x_reg);

            for (int i = 0; i < 3; i++)
            begin
                c_eye_reg[i] <= b_eye_reg[i];
                c_f_reg[i]   <= b_f_reg[i];
            end
            c_ok_reg   <= b_ok_reg;
            c_d_reg[0] <= CW'(b_p_reg[0]) - CW'(b_p_reg[1]);
            c_d_reg[1] <= CW'(b_p_reg[2]) - CW'(b_p_reg[3]);
            c_d_reg[2] <= CW'(b_p_reg[4]) - CW'(b_p_reg[5]);
        end
    end

    lvm_unitize #(
        .VW        (CW),
        .SW        (SW2),
        .FRAC_BITS (FRAC_BITS)
    ) u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_vec    (c_d_reg),
        .in_side   ({c_eye_reg[0], c_eye_reg[1], c_eye_reg[2],
                     c_f_reg[0], c_f_reg[1], c_f_reg[2], c_ok_reg}),
        .out_valid (u2_valid),
        .out_unit  (u2_r),
        .out_ok    (u2_ok),
        .out_side  (u2_side)
    );

    assign u2_f[2]   = $signed(u2_side[1 +: UW]);
    assign u2_f[1]   = $signed(u2_side[1 + UW +: UW]);
    assign u2_f[0]   = $signed(u2_side[1 + 2 * UW +: UW]);
    assign u2_eye[2] = $signed(u2_side[1 + 3 * UW +: CDW]);
    assign u2_eye[1] = $signed(u2_side[1 + 3 * UW + CDW +: CDW]);
    assign u2_eye[0] = $signed(u2_side[1 + 3 * UW + 2 * CDW +: CDW]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_rnd[i] = rnd(64'(e_ur_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_eye_reg[i] <= u2_eye[i];
                d_r_reg[i]   <= u2_r[i];
                d_f_reg[i]   <= u2_f[i];
                d_re_reg[i]  <= PRW'(u2_r[i]) * PRW'(u2_eye[i]);
                d_fe_reg[i]  <= PRW'(u2_f[i]) * PRW'(u2_eye[i]);
            end
            // degenerate if either vector had zero length
            d_ok_reg    <= u2_ok && u2_side[0];
            d_rf_reg[0] <= RFW'(u2_r[1]) * RFW'(u2_f[2]);
            d_rf_reg[1] <= RFW'(u2_r[2]) * RFW'(u2_f[1]);
            d_rf_reg[2] <= RFW'(u2_r[2]) * RFW'(u2_f[0]);
            d_rf_reg[3] <= RFW'(u2_r[0]) * RFW'(u2_f[2]);
            d_rf_reg[4] <= RFW'(u2_r[0]) * RFW'(u2_f[1]);
            d_rf_reg[5] <= RFW'(u2_r[1]) * RFW'(u2_f[0]);

            for (int i = 0; i < 3; i++)
            begin
                e_eye_reg[i] <= d_eye_reg[i];
                e_r_reg[i]   <= d_r_reg[i];
                e_f_reg[i]   <= d_f_reg[i];
            end
            e_ok_reg    <= d_ok_reg;
            e_ur_reg[0] <= UWR'(d_rf_reg[0]) - UWR'(d_rf_reg[1]);
            e_ur_reg[1] <= UWR'(d_rf_reg[2]) - UWR'(d_rf_reg[3]);
            e_ur_reg[2] <= UWR'(d_rf_reg[4]) - UWR'(d_rf_reg[5]);
            e_dr_reg    <= DOTW'(d_re_reg[0]) + DOTW'(d_re_reg[1]) + DOTW'(d_re_reg[2]);
            e_df_reg    <= DOTW'(d_fe_reg[0]) + DOTW'(d_fe_reg[1]) + DOTW'(d_fe_reg[2]);

            for (int i = 0; i < 3; i++)
            begin
                g_eye_reg[i] <= e_eye_reg[i];
                g_r_reg[i]   <= e_r_reg[i];
                g_f_reg[i]   <= e_f_reg[i];
                g_u_reg[i]   <= UW2'(u_rnd[i]);
            end
            g_ok_reg <= e_ok_reg;
            g_tr_reg <= sat(-rnd(64'(e_dr_reg)));
            g_tf_reg <= sat(rnd(64'(e_df_reg)));

            for (int i = 0; i < 3; i++)
            begin
                h_r_reg[i]  <= g_r_reg[i];
                h_f_reg[i]  <= g_f_reg[i];
                h_u_reg[i]  <= g_u_reg[i];
                h_ue_reg[i] <= UEW'(g_u_reg[i]) * UEW'(g_eye_reg[i]);
            end
            h_ok_reg <= g_ok_reg;
            h_tr_reg <= g_tr_reg;
            h_tf_reg <= g_tf_reg;

            for (int i = 0; i < 3; i++)
            begin
                j_r_reg[i] <= h_r_reg[i];
                j_f_reg[i] <= h_f_reg[i];
                j_u_reg[i] <= h_u_reg[i];
            end
            j_ok_reg <= h_ok_reg;
            j_tr_reg <= h_tr_reg;
            j_tf_reg <= h_tf_reg;
            j_du_reg <= DUW'(h_ue_reg[0]) + DUW'(h_ue_reg[1]) + DUW'(h_ue_reg[2]);

            for (int i = 0; i < 3; i++)
            begin
                s_r_reg[i] <= j_r_reg[i];
                s_f_reg[i] <= j_f_reg[i];
                s_u_reg[i] <= j_u_reg[i];
            end
            s_t_reg[0] <= j_tr_reg;
            s_t_reg[1] <= sat(-rnd(64'(j_du_reg)));
            s_t_reg[2] <= j_tf_reg;
            s_deg_reg  <= !j_ok_reg;
        end
    end

    always_comb
    begin
        case (col_reg)
            2'd0:
            begin
                elem_0 = CDW'(s_r_reg[0]);
                elem_1 = CDW'(s_u_reg[0]);
                elem_2 = -CDW'(s_f_reg[0]);
                elem_3 = '0;
            end
            2'd1:
            begin
                elem_0 = CDW'(s_r_reg[1]);
                elem_1 = CDW'(s_u_reg[1]);
                elem_2 = -CDW'(s_f_reg[1]);
                elem_3 = '0;
            end
            2'd2:
            begin
                elem_0 = CDW'(s_r_reg[2]);
                elem_1 = CDW'(s_u_reg[2]);
                elem_2 = -CDW'(s_f_reg[2]);
                elem_3 = '0;
            end
            default:
            begin
                elem_0 = s_t_reg[0];
                elem_1 = s_t_reg[1];
                elem_2 = s_t_reg[2];
                elem_3 = ONE_Q;
            end
        endcase
    end

    assign out_valid    = s_valid_reg;
    assign column_index = col_reg;
    assign degenerate   = s_deg_reg;
    assign last         = (col_reg == lvm_pkg::LAST_COL);

    `LVM_ASSERT_IMPL(a_ready_only_at_end, clk, rst_n, in_ready, !out_valid || column_index == lvm_pkg::LAST_COL)
    `LVM_ASSERT_NEXT(a_col_step, clk, rst_n, out_valid && out_ready && !last, out_valid && column_index == $past(column_index) + 2'd1)
    `LVM_ASSERT_NEXT(a_deg_steady, clk, rst_n, out_valid && out_ready && !last, degenerate == $past(degenerate))
    `LVM_ASSERT_NEXT(a_refill, clk, rst_n, out_valid && out_ready && last && j_valid_reg, out_valid && column_index == 2'd0)

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int FB = lvm_pkg::FRAC_BITS_DEF;
    localparam int IDXW = lvm_pkg::CFG_IDX_W;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        logic [1:0]  col;
        logic [31:0] e0, e1, e2, e3;
        logic        degen;
        logic        lst;
    } column_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] column_index;
    logic signed [31:0] elem_0, elem_1, elem_2, elem_3;
    logic degenerate, last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDXW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    column_t expected_cols[$];
    longint  target_pos[3];
    longint  world_up[3];
    int      errors = 0;
    int      burst_left = 0;
    int      hold_left = 0;
    logic    hold_req = 1'b0;
    logic    hold_ack = 1'b0;
    int      cycle_cnt = 0;
    int      quiet_cycles = 0;

    lookat_view_matrix u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .column_index(column_index),
        .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
        .degenerate(degenerate), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------- view matrix predictor ----------------

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_frac(input longint x);
        return (x + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // returns 0 for a zero-length vector
    function automatic bit normalize(input longint v[3], output longint u[3]);
        longint unsigned mag[3], m, sum, len, q;
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? longint'(0) - v[i] : v[i];
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
        begin
            u[0] = 0; u[1] = 0; u[2] = 0;
            return 1'b0;
        end
        while (m >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
            m <<= 1;
        end
        for (int i = 0; i < 3; i++)
            sum += mag[i] * mag[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << FB) + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void predict_view(input logic [31:0] ex, ey, ez);
        longint eye[3], d[3], f[3], c[3], r[3], u[3], t[3];
        bit ok;
        column_t col;
        eye[0] = longint'(signed'(ex));
        eye[1] = longint'(signed'(ey));
        eye[2] = longint'(signed'(ez));
        for (int i = 0; i < 3; i++)
            d[i] = target_pos[i] - eye[i];
        ok = normalize(d, f);
        c[0] = f[1] * world_up[2] - f[2] * world_up[1];
        c[1] = f[2] * world_up[0] - f[0] * world_up[2];
        c[2] = f[0] * world_up[1] - f[1] * world_up[0];
        ok = normalize(c, r) && ok;
        u[0] = round_frac(r[1] * f[2] - r[2] * f[1]);
        u[1] = round_frac(r[2] * f[0] - r[0] * f[2]);
        u[2] = round_frac(r[0] * f[1] - r[1] * f[0]);
        t[0] = clamp32(-round_frac(r[0] * eye[0] + r[1] * eye[1] + r[2] * eye[2]));
        t[1] = clamp32(-round_frac(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]));
        t[2] = clamp32(round_frac(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]));
        for (int k = 0; k < 4; k++)
        begin
            col.col = k[1:0];
            col.degen = !ok;
            col.lst = (k[1:0] == lvm_pkg::LAST_COL);
            if (k < 3)
            begin
                col.e0 = r[k][31:0];
                col.e1 = u[k][31:0];
                col.e2 = 32'(-f[k]);
                col.e3 = '0;
            end
            else
            begin
                col.e0 = t[0][31:0];
                col.e1 = t[1][31:0];
                col.e2 = t[2][31:0];
                col.e3 = ONE;
            end
            expected_cols.insert(expected_cols.size(), col);
        end
    endfunction

    // ---------------- drivers ----------------

    task automatic send_eye(input logic [31:0] ex, ey, ez);
        if (burst_left == 0)
        begin
            // a quarter of the bursts come back to back
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        eye_x <= ex;
        eye_y <= ey;
        eye_z <= ez;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_view(ex, ey, ez);
        burst_left--;
    endtask

    task automatic drain();
        int n;
        in_valid <= 1'b0;
        burst_left = 0;
        n = 0;
        while (expected_cols.size() > 0 && n < 40000)
        begin
            @(posedge clk);
            n++;
        end
        if (expected_cols.size() > 0)
            report_mismatch("drain", 0, expected_cols.size());
        // every eye yields results, so only a few trailing cycles are needed
        repeat (8) @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            lvm_pkg::CFG_TARGET_X: target_pos[0] = longint'(signed'(data));
            lvm_pkg::CFG_TARGET_Y: target_pos[1] = longint'(signed'(data));
            lvm_pkg::CFG_TARGET_Z: target_pos[2] = longint'(signed'(data));
            lvm_pkg::CFG_UPVEC_X:  world_up[0] = longint'(signed'(data));
            lvm_pkg::CFG_UPVEC_Y:  world_up[1] = longint'(signed'(data));
            lvm_pkg::CFG_UPVEC_Z:  world_up[2] = longint'(signed'(data));
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [31:0] tx, ty, tz, ux, uy, uz);
        write_reg(lvm_pkg::CFG_TARGET_X, tx);
        write_reg(lvm_pkg::CFG_TARGET_Y, ty);
        write_reg(lvm_pkg::CFG_TARGET_Z, tz);
        write_reg(lvm_pkg::CFG_UPVEC_X, ux);
        write_reg(lvm_pkg::CFG_UPVEC_Y, uy);
        write_reg(lvm_pkg::CFG_UPVEC_Z, uz);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? MAXV : MINV;
            2: return 32'($urandom_range(0, 20 * 65536)) - 32'(10 * 65536);
            3: return 32'($urandom_range(0, 16)) - 32'd8;
            default: return 32'($urandom_range(0, 2000 * 65536)) - 32'(1000 * 65536);
        endcase
    endfunction

    task automatic random_camera();
        logic [31:0] v[6];
        for (int i = 0; i < 6; i++)
            v[i] = rand_coord();
        if ($urandom_range(0, 7) == 0)
        begin
            v[3] = '0; v[4] = '0; v[5] = '0;
        end
        set_camera(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    // ---------------- result check ----------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_cnt);
        errors++;
    endtask

    always @(posedge clk)
    begin
        column_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_cols.size() == 0)
                report_mismatch("unexpected column transfer", column_index, 0);
            else
            begin
                w = expected_cols.pop_front();
                if (column_index !== w.col) report_mismatch("column_index", column_index, w.col);
                if (elem_0 !== w.e0) report_mismatch("elem_0", elem_0, w.e0);
                if (elem_1 !== w.e1) report_mismatch("elem_1", elem_1, w.e1);
                if (elem_2 !== w.e2) report_mismatch("elem_2", elem_2, w.e2);
                if (elem_3 !== w.e3) report_mismatch("elem_3", elem_3, w.e3);
                if (degenerate !== w.degen) report_mismatch("degenerate", degenerate, w.degen);
                if (last !== w.lst) report_mismatch("last", last, w.lst);
            end
        end
    end

    // receiver stall pattern: free running, random, heavy, plus forced hold-off
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            case ((cycle_cnt / 300) % 3)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || (!in_valid && !cfg_valid && expected_cols.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_default_camera();
        send_eye('0, '0, 5 * ONE);
        send_eye('0, '0, '0);            // eye on the target
        send_eye('0, 3 * ONE, '0);       // looking along up
        send_eye(MAXV, MAXV, MAXV);
        send_eye(MINV, MINV, MINV);
        send_eye(MAXV, MINV, 32'd1);
        send_eye(32'd1, '0, '0);
        send_eye(ONE, 2 * ONE, -32'sd3 * ONE);
        drain();
    endtask

    task automatic test_register_extremes();
        set_camera(MAXV, MINV, MAXV, MINV, MAXV, MINV);
        send_eye(MINV, MAXV, MINV);
        send_eye('0, '0, '0);
        send_eye(MAXV, MINV, MAXV);      // eye on the target
        drain();
        set_camera(MINV, MAXV, MINV, '0, '0, '0);   // zero up vector
        send_eye('0, '0, '0);
        send_eye(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
        drain();
        // writes to unused indexes must not change anything
        write_reg(IDXW'(int'(lvm_pkg::CFG_UPVEC_Z) + 1), 32'hdead_beef);
        write_reg(IDXW'(int'(lvm_pkg::CFG_UPVEC_Z) + 2), 32'h1234_5678);
        set_camera(10 * ONE, '0, '0, '0, '0, ONE);
        send_eye('0, '0, '0);
        send_eye(10 * ONE, '0, 7 * ONE);   // forward parallel to up
        send_eye(-32'sd7, 32'd9, 32'd3);
        drain();
    endtask

    task automatic test_full_backpressure();
        set_camera(ONE, 2 * ONE, 3 * ONE, '0, ONE, '0);
        hold_req <= !hold_req;
        burst_left = 1000;
        for (int i = 0; i < 40; i++)
            send_eye(rand_coord(), rand_coord(), rand_coord());
        drain();
    endtask

    task automatic test_pause_until_empty();
        for (int i = 0; i < 6; i++)
            send_eye(rand_coord(), rand_coord(), rand_coord());
        in_valid <= 1'b0;
        burst_left = 0;
        wait (expected_cols.size() == 0);
        @(posedge clk);
        for (int i = 0; i < 6; i++)
            send_eye(rand_coord(), rand_coord(), rand_coord());
        drain();
    endtask

    task automatic test_random_views();
        logic [31:0] ex, ey, ez;
        for (int i = 0; i < 320; i++)
        begin
            if (i % 60 == 0)
            begin
                drain();
                random_camera();
            end
            ex = rand_coord();
            ey = rand_coord();
            ez = rand_coord();
            if ($urandom_range(0, 19) == 0)
            begin
                ex = target_pos[0][31:0];
                ey = target_pos[1][31:0];
                ez = target_pos[2][31:0];
            end
            send_eye(ex, ey, ez);
        end
        drain();
    endtask

    initial
    begin
        target_pos = '{0, 0, 0};
        world_up = '{0, longint'(1) << FB, 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_camera();
        test_register_extremes();
        test_full_backpressure();
        test_pause_until_empty();
        test_random_views();
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
